// ----- sv/lpfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfe_pkg
// Shared constants, register indexes and the sRGB8 code boundary table builder.
// ----------------------------------------------------------------------------
package lpfe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // boundary entries wide enough for 2^24 + 1
  localparam int THR_W = 26;
  localparam int BIG_W = 320;
  localparam int SRGB_LIN_BOUNDS = 10;
  localparam int SRGB_CODES = 255;

  typedef enum logic [0:0] {
    REG_FORMAT_MODE     = 1'b0,
    REG_COMPONENT_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    FMT_UNORM8  = 2'd0,
    FMT_SRGB8   = 2'd1,
    FMT_UNORM16 = 2'd2,
    FMT_A2RGB10 = 2'd3
  } fmt_t;

  typedef logic [SRGB_CODES-1:0][THR_W-1:0] thr_tab_t;

  // exact test of x = v / 2^frac against the boundary between codes b and b+1
  function automatic logic srgb_passes(int frac, int b, logic [THR_W-1:0] v);
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] base;
    int i;
    if (b < SRGB_LIN_BOUNDS) begin
      lhs = BIG_W'(v) * BIG_W'(329460);
      rhs = (BIG_W'((2 * b + 1) * 50)) << frac;
    end else begin
      lhs = BIG_W'(v);
      for (i = 0; i < 4; i++) lhs = lhs * BIG_W'(v);
      for (i = 0; i < 12; i++) lhs = lhs * BIG_W'(10761);
      base = BIG_W'(40 * b + 581);
      rhs = base;
      for (i = 0; i < 11; i++) rhs = rhs * base;
      rhs = rhs << (5 * frac);
    end
    return lhs >= rhs;
  endfunction

  // smallest v that passes boundary b; 2^frac + 1 when none does
  function automatic logic [THR_W-1:0] srgb_thr(int frac, int b);
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] hi;
    logic [THR_W-1:0] mid;
    int i;
    lo = '0;
    hi = (THR_W'(1) << frac) + THR_W'(1);
    for (i = 0; i < 32; i++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (srgb_passes(frac, b, mid)) hi = mid;
        else lo = mid + THR_W'(1);
      end
    end
    return lo;
  endfunction

  function automatic thr_tab_t srgb_thr_table(int frac);
    thr_tab_t t;
    int b;
    for (b = 0; b < SRGB_CODES; b++) t[b] = srgb_thr(frac, b);
    return t;
  endfunction

endpackage

// ----- sv/linear_pixel_format_encoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_pixel_format_encoder_top
// Linear pixel to unorm8 / srgb8 / unorm16 / a2r10g10b10 packer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel word per handshake, four signed linear components with
//           FRAC_BITS fraction bits plus an end-of-image flag.
//   out_* : one packed word per pixel, byte count and the copied flag.
//   cfg_* : write format mode (index 0) and component count (index 1) while
//           no word is in flight; takes effect for following words.
// From input accept to output valid a word passes a clamp stage,
// eight sRGB bit stages (one compare against the boundary table per stage,
// quantizers alongside) and the output pack register.
// Throughput is one word per cycle while not stalled; the whole pipe advances together.
// When the receiver stalls the pipe holds every stage, and in_ready drops
// only while the output register is full and not taken.
// Reset empties the pipe and sets unorm8 with four components.
// ----------------------------------------------------------------------------
module linear_pixel_format_encoder_top
  import lpfe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [19:0] in_comp_zero,
  input  logic signed [19:0] in_comp_one,
  input  logic signed [19:0] in_comp_two,
  input  logic signed [19:0] in_comp_three,
  input  logic               in_last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_packed_word,
  output logic [3:0]         out_byte_count,
  output logic               out_last_out,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [2:0]         cfg_data
);

  localparam int VW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 18;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [3:0][7:0]  q8;
    logic [3:0][15:0] q16;
    logic [2:0][9:0]  q10;
    logic [1:0]       q2;
    logic [1:0]       mode;
    logic [2:0]       n;
    logic             last;
  } side_t;

  logic [1:0] mode_r;
  logic [2:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= FMT_UNORM8;
      count_r <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT_MODE:     mode_r  <= cfg_data[1:0];
        REG_COMPONENT_COUNT: count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  function automatic logic [VW-1:0] clamp(logic signed [19:0] c);
    logic signed [31:0] ext;
    logic signed [31:0] one;
    ext = 32'(c);
    one = 32'sd1 <<< FRAC_BITS;
    if (ext < 0) return '0;
    else if (ext > one) return VW'(one);
    else return VW'(ext);
  endfunction

  // clamp stage
  logic [3:0][VW-1:0] v_r;
  logic [1:0]         mode_s1_r;
  logic [2:0]         n_s1_r;
  logic               last_s1_r;
  logic [8:0]         vld_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r[0]    <= clamp(in_comp_zero);
      v_r[1]    <= clamp(in_comp_one);
      v_r[2]    <= clamp(in_comp_two);
      v_r[3]    <= clamp(in_comp_three);
      mode_s1_r <= mode_r;
      n_s1_r    <= (count_r == 3'd0) ? 3'd1 : ((count_r > 3'd4) ? 3'd4 : count_r);
      last_s1_r <= in_last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[7:0], in_valid};
    end
  end

  // quantizers: v*M done as shift and subtract (shift and add for the 2-bit alpha)
  side_t side_nxt;
  always_comb begin
    logic [PW-1:0] vx;
    logic [PW-1:0] t8;
    logic [PW-1:0] t16;
    logic [PW-1:0] t10;
    logic [PW-1:0] t2;
    side_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      vx  = PW'(v_r[k]);
      t8  = (vx << 8) - vx + HALF;
      t16 = (vx << 16) - vx + HALF;
      t10 = (vx << 10) - vx + HALF;
      t2  = (vx << 1) + vx + HALF;
      side_nxt.q8[k]  = t8[FRAC_BITS +: 8];
      side_nxt.q16[k] = t16[FRAC_BITS +: 16];
      if (k < 3) side_nxt.q10[k] = t10[FRAC_BITS +: 10];
      else side_nxt.q2 = t2[FRAC_BITS +: 2];
    end
    side_nxt.mode = mode_s1_r;
    side_nxt.n    = n_s1_r;
    side_nxt.last = last_s1_r;
  end

  side_t side_r [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < 8; i++) side_r[i] <= side_r[i-1];
    end
  end

  logic [3:0][7:0] srgb;
  for (genvar k = 0; k < 4; k++) begin : g_lane
    lpfe_srgb_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (adv),
      .v_i    (v_r[k]),
      .code_o (srgb[k])
    );
  end

  // pack
  logic [63:0] word_nxt;
  logic [3:0]  bytes_nxt;
  always_comb begin
    side_t s;
    logic [7:0] c;
    s = side_r[7];
    c = '0;
    word_nxt = '0;
    bytes_nxt = 4'd4;
    case (s.mode)
      FMT_A2RGB10: begin
        word_nxt[31:30] = (s.n < 3'd4) ? 2'd3 : s.q2;
        word_nxt[29:20] = s.q10[0];
        word_nxt[19:10] = s.q10[1];
        word_nxt[9:0]   = s.q10[2];
        bytes_nxt = 4'd4;
      end
      FMT_UNORM16: begin
        for (int k = 0; k < 4; k++) begin
          if (3'(k) < s.n) word_nxt[16*k +: 16] = s.q16[k];
        end
        bytes_nxt = {s.n, 1'b0};
      end
      default: begin
        for (int k = 0; k < 4; k++) begin
          c = (s.mode == FMT_SRGB8) ? srgb[k] : s.q8[k];
          if (3'(k) < s.n) word_nxt[8*k +: 8] = c;
        end
        bytes_nxt = {1'b0, s.n};
      end
    endcase
  end

  logic [63:0] word_r;
  logic [3:0]  bytes_r;
  logic        last_r;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[8];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r  <= word_nxt;
      bytes_r <= bytes_nxt;
      last_r  <= side_r[7].last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_word = word_r;
  assign out_byte_count  = bytes_r;
  assign out_last_out    = last_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (bytes_r >= 4'd1 && bytes_r <= 4'd8))
    else $error("byte count out of range");

  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bytes_r <= 4'd4) |-> (word_r[63:32] == 32'd0))
    else $error("unused upper bits not zero");

  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted word lost in clamp stage");
`endif

endmodule

// ----- sv/lpfe_srgb_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfe_srgb_lane
// Eight-stage sRGB8 encoder: one code bit per stage, msb first, by comparing
// the clamped linear value against the constant code boundary table.
// ----------------------------------------------------------------------------
module lpfe_srgb_lane
  import lpfe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS:0]   v_i,
  output logic [7:0]           code_o
);

  localparam thr_tab_t THR = srgb_thr_table(FRAC_BITS);

  logic [FRAC_BITS:0] v_r    [7];
  logic [7:0]         code_r [8];

  for (genvar i = 0; i < 8; i++) begin : g_stage
    logic [FRAC_BITS:0] v_prev;
    logic [7:0]         code_prev;
    logic [7:0]         cand;
    logic [7:0]         bidx;
    logic [7:0]         code_nxt;

    if (i == 0) begin : g_first
      assign v_prev    = v_i;
      assign code_prev = '0;
    end else begin : g_rest
      assign v_prev    = v_r[i-1];
      assign code_prev = code_r[i-1];
    end

    always_comb begin
      cand     = code_prev | (8'd1 << (7 - i));
      bidx     = cand - 8'd1;
      code_nxt = (THR_W'(v_prev) >= THR[bidx]) ? cand : code_prev;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        code_r[i] <= code_nxt;
      end
    end

    // the last stage needs no value copy
    if (i < 7) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          v_r[i] <= v_prev;
        end
      end
    end
  end

  assign code_o = code_r[7];

endmodule
